/* src/mht_pkg.sv */
package mht_pkg;

    localparam int CAPACITY_DEFAULT = 64;
    localparam int DATA_W = 32;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_SEARCH = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_SHIFT,
        ST_SHIFT_WR,
        ST_REBUILD,
        ST_SD_TEST,
        ST_SD_NODE,
        ST_SD_LEFT,
        ST_SD_RIGHT,
        ST_SD_SWAP,
        ST_SD_SWAP2,
        ST_FIN,
        ST_FIN_ROOT,
        ST_FIN_SCAN,
        ST_FIN_CMP
    } state_t;

endpackage

/* src/mht_ram.sv */
module mht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* src/min_heap_table.sv */
// Binary min heap kept in array order in one single-port-read, single-port-write
// RAM. A transaction is taken when start is high and busy is low; its one result
// appears for a single cycle with done high and must be captured then, since the
// block cannot be held off. Every read goes through the one RAM read port, so
// an item takes as long as the work on it: search scans the entries in order
// up to a match or the end, insert rebuilds the heap with a sift-down from each
// parent, roughly N/2 of them (N the count), and remove does the search, shifts
// the later entries down by one index, then the same rebuild. Every operation
// ends with a scan of the leaves for the maximum; the smallest is the root. The
// smallest and largest outputs are set to zero when an operation leaves the heap
// empty.
module min_heap_table #(
    parameter int CAPACITY = mht_pkg::CAPACITY_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        func,
    input  logic signed [31:0]                value,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [$clog2(CAPACITY)-1:0]       found_index,
    output logic signed [31:0]                smallest,
    output logic signed [31:0]                largest,
    output logic [$clog2(CAPACITY+1)-1:0]     entry_count,
    output logic                              is_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = mht_pkg::DATA_W;

    mht_pkg::state_t state_reg, state_next;
    logic [1:0]    func_reg, func_next;
    logic [DW-1:0] value_reg, value_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] node_reg, node_next;
    logic [CW-1:0] best_reg, best_next;
    logic [DW-1:0] nval_reg, nval_next;
    logic [DW-1:0] bval_reg, bval_next;
    logic [1:0]    status_reg, status_next;
    logic [AW-1:0] index_reg, index_next;
    logic [DW-1:0] small_reg, small_next;
    logic [DW-1:0] large_reg, large_next;
    logic          done_reg, done_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;

    logic [CW:0]   lchild;
    logic [CW:0]   rchild;
    logic [CW:0]   count_ext;

    assign lchild    = {node_reg, 1'b1};
    assign rchild    = lchild + 1'b1;
    assign count_ext = {1'b0, count_reg};

    mht_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mht_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        value_reg  <= value_next;
        k_reg      <= k_next;
        node_reg   <= node_next;
        best_reg   <= best_next;
        nval_reg   <= nval_next;
        bval_reg   <= bval_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        small_reg  <= small_next;
        large_reg  <= large_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        value_next  = value_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        node_next   = node_reg;
        best_next   = best_reg;
        nval_next   = nval_reg;
        bval_next   = bval_reg;
        status_next = status_reg;
        index_next  = index_reg;
        small_next  = small_reg;
        large_next  = large_reg;
        done_next   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = nval_reg;
        rd_addr     = '0;

        case (state_reg)
            mht_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    func_next   = func;
                    value_next  = value;
                    status_next = mht_pkg::STATUS_OK;
                    index_next  = '0;
                    k_next      = '0;
                    case (func)
                        mht_pkg::FUNC_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = mht_pkg::STATUS_FULL;
                                state_next  = mht_pkg::ST_FIN;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                wr_data    = value;
                                count_next = count_reg + 1'b1;
                                state_next = mht_pkg::ST_REBUILD;
                            end
                        end
                        mht_pkg::FUNC_REMOVE,
                        mht_pkg::FUNC_SEARCH:
                        begin
                            state_next = mht_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            state_next = mht_pkg::ST_FIN;
                        end
                    endcase
                end
            end

            mht_pkg::ST_SCAN:
            begin
                if (k_reg == count_reg)
                begin
                    status_next = mht_pkg::STATUS_NOT_FOUND;
                    state_next  = mht_pkg::ST_FIN;
                end
                else
                begin
                    rd_addr    = k_reg[AW-1:0];
                    state_next = mht_pkg::ST_SCAN_CHK;
                end
            end

            mht_pkg::ST_SCAN_CHK:
            begin
                if (rd_data == value_reg)
                begin
                    if (func_reg == mht_pkg::FUNC_SEARCH)
                    begin
                        index_next = k_reg[AW-1:0];
                        state_next = mht_pkg::ST_FIN;
                    end
                    else
                    begin
                        state_next = mht_pkg::ST_SHIFT;
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = mht_pkg::ST_SCAN;
                end
            end

            mht_pkg::ST_SHIFT:
            begin
                if (({1'b0, k_reg} + 1'b1) < count_ext)
                begin
                    rd_addr    = AW'(k_reg + 1'b1);
                    state_next = mht_pkg::ST_SHIFT_WR;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = mht_pkg::ST_REBUILD;
                end
            end

            mht_pkg::ST_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = k_reg[AW-1:0];
                wr_data    = rd_data;
                k_next     = k_reg + 1'b1;
                state_next = mht_pkg::ST_SHIFT;
            end

            mht_pkg::ST_REBUILD:
            begin
                k_next     = count_reg >> 1;
                node_next  = count_reg >> 1;
                state_next = mht_pkg::ST_SD_TEST;
            end

            mht_pkg::ST_SD_TEST:
            begin
                if (lchild >= count_ext)
                begin
                    // This subtree is in order; move on to the next parent, or finish after the root.
                    if (k_reg == '0)
                    begin
                        state_next = mht_pkg::ST_FIN;
                    end
                    else
                    begin
                        k_next    = k_reg - 1'b1;
                        node_next = k_reg - 1'b1;
                    end
                end
                else
                begin
                    rd_addr    = node_reg[AW-1:0];
                    state_next = mht_pkg::ST_SD_NODE;
                end
            end

            mht_pkg::ST_SD_NODE:
            begin
                nval_next  = rd_data;
                rd_addr    = lchild[AW-1:0];
                state_next = mht_pkg::ST_SD_LEFT;
            end

            mht_pkg::ST_SD_LEFT:
            begin
                best_next = node_reg;
                bval_next = nval_reg;
                if ($signed(rd_data) < $signed(nval_reg))
                begin
                    best_next = lchild[CW-1:0];
                    bval_next = rd_data;
                end
                if (rchild < count_ext)
                begin
                    rd_addr    = rchild[AW-1:0];
                    state_next = mht_pkg::ST_SD_RIGHT;
                end
                else
                begin
                    state_next = mht_pkg::ST_SD_SWAP;
                end
            end

            mht_pkg::ST_SD_RIGHT:
            begin
                if ($signed(rd_data) < $signed(bval_reg))
                begin
                    best_next = rchild[CW-1:0];
                    bval_next = rd_data;
                end
                state_next = mht_pkg::ST_SD_SWAP;
            end

            mht_pkg::ST_SD_SWAP:
            begin
                if (best_reg == node_reg)
                begin
                    if (k_reg == '0)
                    begin
                        state_next = mht_pkg::ST_FIN;
                    end
                    else
                    begin
                        k_next     = k_reg - 1'b1;
                        node_next  = k_reg - 1'b1;
                        state_next = mht_pkg::ST_SD_TEST;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = best_reg[AW-1:0];
                    wr_data    = nval_reg;
                    state_next = mht_pkg::ST_SD_SWAP2;
                end
            end

            mht_pkg::ST_SD_SWAP2:
            begin
                wr_en      = 1'b1;
                wr_addr    = node_reg[AW-1:0];
                wr_data    = bval_reg;
                node_next  = best_reg;
                state_next = mht_pkg::ST_SD_TEST;
            end

            mht_pkg::ST_FIN:
            begin
                if (count_reg == '0)
                begin
                    small_next = '0;
                    large_next = '0;
                    done_next  = 1'b1;
                    state_next = mht_pkg::ST_IDLE;
                end
                else
                begin
                    rd_addr    = '0;
                    state_next = mht_pkg::ST_FIN_ROOT;
                end
            end

            mht_pkg::ST_FIN_ROOT:
            begin
                small_next = rd_data;
                large_next = rd_data;
                k_next     = count_reg >> 1;
                state_next = mht_pkg::ST_FIN_SCAN;
            end

            mht_pkg::ST_FIN_SCAN:
            begin
                if (k_reg < count_reg)
                begin
                    rd_addr    = k_reg[AW-1:0];
                    state_next = mht_pkg::ST_FIN_CMP;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = mht_pkg::ST_IDLE;
                end
            end

            mht_pkg::ST_FIN_CMP:
            begin
                if ($signed(large_reg) < $signed(rd_data))
                begin
                    large_next = rd_data;
                end
                k_next     = k_reg + 1'b1;
                state_next = mht_pkg::ST_FIN_SCAN;
            end

            default:
            begin
                state_next = mht_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != mht_pkg::ST_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found_index = index_reg;
    assign smallest    = small_reg;
    assign largest     = large_reg;
    assign entry_count = count_reg;
    assign is_empty    = (count_reg == '0);

endmodule
